[sv/ols_pkg.sv]
// ============================================================================
// ols_pkg: shared types and constants for the offside-rule layout scanner
// Holds item codes, token codes, scan phases, character constants, the
// classified item that travels from the front end to the back end, and the
// keyword match function.
// ============================================================================
`default_nettype none

package ols_pkg;

  // Default depth of the indent stack, base entry included.
  localparam int unsigned MaxLevelsDef = 512;

  // Widths fixed by the item and result formats.
  localparam int unsigned ColW    = 16;
  localparam int unsigned TabW    = 5;
  localparam int unsigned LevelsW = 10;
  localparam int unsigned WordW   = 32;

  // Reset value of the tab width register.
  localparam logic [TabW-1:0] TabWidthRst = 5'd8;

  // Depth of the queue between front and back end.
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_END   = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    TOK_NONE   = 2'd0,
    TOK_INDENT = 2'd1,
    TOK_DEDENT = 2'd2,
    TOK_SEP    = 2'd3
  } token_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SPACE   = 3'd1,
    PH_COMMENT = 3'd2,
    PH_UNDER   = 3'd3,
    PH_WORD    = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  // Allow flag positions.
  localparam int unsigned FlIndent = 0;
  localparam int unsigned FlDedent = 1;
  localparam int unsigned FlSep    = 2;
  localparam logic [2:0]  FlAll    = 3'b111;

  // Character codes.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_LOW_LO = 8'h61;
  localparam logic [7:0] CH_LOW_HI = 8'h7A;
  localparam logic [7:0] CH_UP_LO  = 8'h41;
  localparam logic [7:0] CH_UP_HI  = 8'h5A;

  // Continuation keywords, first character in the low byte.
  localparam logic [WordW-1:0] KW_THEN = 32'h6E656874;
  localparam logic [WordW-1:0] KW_ELSE = 32'h65736C65;
  localparam logic [WordW-1:0] KW_ELIF = 32'h66696C65;
  localparam logic [WordW-1:0] KW_WITH = 32'h68746977;
  localparam logic [WordW-1:0] KW_AND  = 32'h00646E61;
  localparam logic [WordW-1:0] KW_OR   = 32'h0000726F;
  localparam logic [WordW-1:0] KW_IN   = 32'h00006E69;

  // Character class bits computed by the front end.
  typedef struct packed {
    logic lf;
    logic cr_ff;
    logic space;
    logic tab;
    logic hash;
    logic op_lead;
    logic under;
    logic lower;
    logic ident;
  } char_cls_t;

  // One classified beat in the queue.
  typedef struct packed {
    kind_e     kind;
    logic [7:0] ch;
    logic [2:0] flags;
    char_cls_t  cls;
  } scan_item_t;

  // Status from the back end for checking.
  typedef struct packed {
    logic cnt_ok;
    logic reload_pend;
    logic top_used;
  } ols_status_t;

  // True when the buffered word is one of the continuation keywords.
  function automatic logic is_keyword(input logic [WordW-1:0] buf_w,
                                      input logic [3:0] len);
    logic hit;
    hit = 1'b0;
    if (len == 4'd4) begin
      hit = (buf_w == KW_THEN) || (buf_w == KW_ELSE) ||
            (buf_w == KW_ELIF) || (buf_w == KW_WITH);
    end else if (len == 4'd3) begin
      hit = (buf_w == KW_AND);
    end else if (len == 4'd2) begin
      hit = (buf_w == KW_OR) || (buf_w == KW_IN);
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

[sv/ols_in_if.sv]
// ============================================================================
// ols_in_if: input channel of the layout scanner
// Valid/ready channel that carries one scan item per beat.
// ============================================================================
`default_nettype none

interface ols_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] ch;
  logic       allow_indent;
  logic       allow_dedent;
  logic       allow_sep;

  modport source (output valid, output kind, output ch, output allow_indent,
                  output allow_dedent, output allow_sep, input ready);
  modport sink   (input valid, input kind, input ch, input allow_indent,
                  input allow_dedent, input allow_sep, output ready);
endinterface

`default_nettype wire

[sv/ols_out_if.sv]
// ============================================================================
// ols_out_if: result channel of the layout scanner
// Valid/ready channel that carries one layout decision per beat.
// ============================================================================
`default_nettype none

interface ols_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] token;
  logic [9:0] levels;

  modport source (output valid, output token, output levels, input ready);
  modport sink   (input valid, input token, input levels, output ready);
endinterface

`default_nettype wire

[sv/offside_rule_layout_scanner.sv]
// ============================================================================
// offside_rule_layout_scanner: indentation layout scanner, top level
// Front end classifies input beats, a two-entry queue decouples it from the
// scan engine, which decides INDENT, DEDENT, SEP or no token once per call.
// ============================================================================
// Result beats are registered, valid the cycle after the scan engine takes the deciding beat from the queue.
// Throughput: one input beat per cycle while the result side keeps up.
// A DEDENT to a level above the base reloads the stack top from memory in the
// next cycle; one to the base level clears it. Reset: stack holds only the base
// level 0, tab width 8, no scan open; the stack memory needs no clearing pass.
`default_nettype none

module offside_rule_layout_scanner
  import ols_pkg::*;
#(
  parameter int unsigned MaxLevels = MaxLevelsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  ols_in_if.sink               in_i,
  ols_out_if.source            out_o,
  input  wire logic            cfg_we_i,
  input  wire logic [TabW-1:0] cfg_wdata_i
);

  logic [TabW-1:0] tab_width_q;
  logic            q_full;
  logic            q_push;
  scan_item_t      q_in_item;
  logic            q_pop;
  logic            q_valid;
  scan_item_t      q_out_item;
  ols_status_t     status;

  // Tab width register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_width_q <= TabWidthRst;
    end else if (cfg_we_i) begin
      tab_width_q <= cfg_wdata_i;
    end
  end

  ols_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (q_in_item)
  );

  ols_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out_item)
  );

  ols_back #(
    .MaxLevels (MaxLevels)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out_item),
    .q_pop_o     (q_pop),
    .tab_width_i (tab_width_q),
    .out_o       (out_o),
    .status_o    (status)
  );

  // The stack depth stays between the base level and the configured maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni) status.cnt_ok)
    else $error("indent stack count out of range");

  // No decision may use the stack top while it is being reloaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   status.reload_pend |-> !status.top_used)
    else $error("stack top used during reload");

  // A reload only follows a dedent decision in the previous cycle; the check itself looks only at the result handshake.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   status.reload_pend |-> $past(out_o.valid == 1'b0 || out_o.ready) &&
                                          $rose(out_o.valid) || $past(out_o.ready))
    else $error("stack reload without a preceding dedent");

endmodule

`default_nettype wire

[sv/ols_ram.sv]
// ============================================================================
// ols_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module ols_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[sv/ols_front.sv]
// ============================================================================
// ols_front: input front end of the layout scanner
// Accepts input beats, classifies the character and hands the classified
// item to the queue. Reserved kind codes are accepted and dropped here.
// ============================================================================
`default_nettype none

module ols_front
  import ols_pkg::*;
(
  ols_in_if.sink          in_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output scan_item_t      q_item_o
);

  char_cls_t cls;
  logic      is_digit;
  logic      is_upper;

  // The queue sets the pace of the input.
  assign in_i.ready = !q_full_i;
  assign q_push_o   = in_i.valid && !q_full_i && (kind_e'(in_i.kind) != KIND_RSVD);

  // Character classification.
  always_comb begin
    cls          = '0;
    is_digit     = (in_i.ch >= CH_DIG_LO) && (in_i.ch <= CH_DIG_HI);
    is_upper     = (in_i.ch >= CH_UP_LO) && (in_i.ch <= CH_UP_HI);
    cls.lf       = (in_i.ch == CH_LF);
    cls.cr_ff    = (in_i.ch == CH_CR) || (in_i.ch == CH_FF);
    cls.space    = (in_i.ch == CH_SPACE);
    cls.tab      = (in_i.ch == CH_TAB);
    cls.hash     = (in_i.ch == CH_HASH);
    cls.under    = (in_i.ch == CH_UNDER);
    cls.lower    = (in_i.ch >= CH_LOW_LO) && (in_i.ch <= CH_LOW_HI);
    cls.ident    = cls.under || is_digit || cls.lower || is_upper;
    case (in_i.ch) inside
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_LT, CH_GT, CH_EQ,
      CH_BANG, CH_CARET, CH_BAR, CH_DOT, CH_COMMA, CH_RPAREN, CH_RBRACK,
      CH_RBRACE: cls.op_lead = 1'b1;
      default:   cls.op_lead = 1'b0;
    endcase
  end

  // Pack the classified item.
  always_comb begin
    q_item_o.kind  = kind_e'(in_i.kind);
    q_item_o.ch    = in_i.ch;
    q_item_o.flags = {in_i.allow_sep, in_i.allow_dedent, in_i.allow_indent};
    q_item_o.cls   = cls;
  end

endmodule

`default_nettype wire

[sv/ols_queue.sv]
// ============================================================================
// ols_queue: short queue between front and back end
// Two-entry register queue of classified items, so that each side can
// stall on its own.
// ============================================================================
`default_nettype none

module ols_queue
  import ols_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire scan_item_t item_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output scan_item_t      item_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  scan_item_t      entry_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = entry_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

[sv/ols_back.sv]
// ============================================================================
// ols_back: scan engine of the layout scanner
// Runs the per-call scan over classified items: column counting, comment
// skipping, the indent decision against the stack top, the statement-start
// test, and the indent stack itself. Drives the registered result channel.
// ============================================================================
`default_nettype none

module ols_back
  import ols_pkg::*;
#(
  parameter int unsigned MaxLevels = MaxLevelsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire scan_item_t      q_item_i,
  output logic                 q_pop_o,
  input  wire logic [TabW-1:0] tab_width_i,
  ols_out_if.source            out_o,
  output ols_status_t          status_o
);

  localparam int unsigned AddrW = $clog2(MaxLevels);
  localparam int unsigned CntW  = $clog2(MaxLevels + 1);

  phase_e            phase_q, phase_d;
  logic [2:0]        flags_q, flags_d;
  logic              saw_q, saw_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [WordW-1:0]  wbuf_q, wbuf_d;
  logic [3:0]        wlen_q, wlen_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ColW-1:0]   top_q, top_d;
  logic              reload_q, reload_d;
  logic              out_valid_q, out_valid_d;
  token_e            token_q, token_d;
  logic [LevelsW-1:0] levels_q, levels_d;

  logic              fire;
  logic              emit;
  token_e            tok;
  logic              push;
  logic              pop;
  logic              used_top;
  logic              dec_go;
  logic              dec_end;
  logic [ColW-1:0]   dec_col;
  logic [TabW-1:0]   add_amt;
  logic [ColW:0]     col_sum;
  logic [ColW-1:0]   col_sat;
  logic [CntW-1:0]   rd_idx;
  logic [ColW-1:0]   ram_rdata;
  logic [CntW+LevelsW-1:0] cnt_ext;

  // Indent stack storage; the top entry is also kept in top_q.
  assign rd_idx = cnt_q - CntW'(2);

  ols_ram #(
    .Width (ColW),
    .Depth (MaxLevels)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (dec_col),
    .raddr_i (rd_idx[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // An item moves on when the result register is free or being drained.
  assign fire    = q_valid_i && (!out_valid_q || out_o.ready);
  assign q_pop_o = fire;

  // Saturating column add for a space or a tab.
  assign add_amt = q_item_i.cls.tab ? tab_width_i : TabW'(1);
  assign col_sum = {1'b0, col_q} + {{(ColW + 1 - TabW){1'b0}}, add_amt};
  assign col_sat = col_sum[ColW] ? {ColW{1'b1}} : col_sum[ColW-1:0];

  // Scan step and indent decision.
  always_comb begin
    phase_d  = phase_q;
    flags_d  = flags_q;
    saw_d    = saw_q;
    col_d    = col_q;
    wbuf_d   = wbuf_q;
    wlen_d   = wlen_q;
    cnt_d    = cnt_q;
    top_d    = top_q;
    emit     = 1'b0;
    tok      = TOK_NONE;
    push     = 1'b0;
    pop      = 1'b0;
    used_top = 1'b0;
    dec_go   = 1'b0;
    dec_end  = 1'b0;
    dec_col  = col_q;

    if (fire) begin
      if (q_item_i.kind == KIND_START) begin
        flags_d = q_item_i.flags;
        col_d   = '0;
        saw_d   = 1'b0;
        wbuf_d  = '0;
        wlen_d  = '0;
        phase_d = PH_SPACE;
      end else if (q_item_i.kind != KIND_RSVD) begin
        case (phase_q)
          PH_SPACE: begin
            if (q_item_i.kind == KIND_END) begin
              saw_d   = 1'b1;
              col_d   = '0;
              dec_go  = 1'b1;
              dec_end = 1'b1;
              dec_col = '0;
            end else if (q_item_i.cls.lf) begin
              saw_d = 1'b1;
              col_d = '0;
            end else if (q_item_i.cls.cr_ff) begin
              col_d = '0;
            end else if (q_item_i.cls.space || q_item_i.cls.tab) begin
              col_d = col_sat;
            end else if (q_item_i.cls.hash) begin
              if (!saw_q) begin
                emit = 1'b1;
                tok  = TOK_NONE;
              end else begin
                phase_d = PH_COMMENT;
              end
            end else begin
              dec_go = 1'b1;
            end
          end
          PH_COMMENT: begin
            if (q_item_i.kind == KIND_END) begin
              saw_d   = 1'b1;
              col_d   = '0;
              dec_go  = 1'b1;
              dec_end = 1'b1;
              dec_col = '0;
            end else if (q_item_i.cls.lf) begin
              saw_d   = 1'b1;
              col_d   = '0;
              phase_d = PH_SPACE;
            end
          end
          PH_UNDER: begin
            emit = 1'b1;
            tok  = (q_item_i.kind == KIND_CHAR && q_item_i.cls.ident) ? TOK_SEP : TOK_NONE;
          end
          PH_WORD: begin
            if (q_item_i.kind == KIND_CHAR && q_item_i.cls.ident) begin
              if (wlen_q[3:2] == 2'b00) begin
                wbuf_d[{wlen_q[1:0], 3'b000} +: 8] = q_item_i.ch;
              end
              wlen_d = wlen_q + 4'd1;
              if (wlen_q == 4'd7) begin
                emit = 1'b1;
                tok  = TOK_SEP;
              end
            end else begin
              emit = 1'b1;
              tok  = is_keyword(wbuf_q, wlen_q) ? TOK_NONE : TOK_SEP;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // Decision against the top of the indent stack.
    if (dec_go) begin
      if (!saw_d) begin
        emit = 1'b1;
        tok  = TOK_NONE;
      end else begin
        used_top = 1'b1;
        if (flags_q[FlDedent] && (dec_col < top_q)) begin
          pop  = (cnt_q > CntW'(1));
          emit = 1'b1;
          tok  = TOK_DEDENT;
        end else if (flags_q == FlAll) begin
          emit = 1'b1;
          tok  = TOK_NONE;
        end else if (flags_q[FlIndent] && (dec_col > top_q)) begin
          push = (cnt_q < CntW'(MaxLevels));
          emit = 1'b1;
          tok  = TOK_INDENT;
        end else if (flags_q[FlSep] && !dec_end && (dec_col == top_q)) begin
          if (q_item_i.cls.op_lead) begin
            emit = 1'b1;
            tok  = TOK_NONE;
          end else if (q_item_i.cls.under) begin
            phase_d = PH_UNDER;
          end else if (q_item_i.cls.lower) begin
            wbuf_d  = {{(WordW - 8){1'b0}}, q_item_i.ch};
            wlen_d  = 4'd1;
            phase_d = PH_WORD;
          end else begin
            emit = 1'b1;
            tok  = TOK_SEP;
          end
        end else begin
          emit = 1'b1;
          tok  = TOK_NONE;
        end
      end
    end

    // The stack top comes back from memory in the cycle after a pop.
    if (reload_q) begin
      top_d = ram_rdata;
    end
    if (push) begin
      cnt_d = cnt_q + CntW'(1);
      top_d = dec_col;
    end
    if (pop) begin
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(2)) begin
        top_d = '0;
      end
    end

    if (emit) begin
      phase_d = PH_DONE;
    end
  end

  assign reload_d = pop && (cnt_q != CntW'(2));
  assign cnt_ext  = {{LevelsW{1'b0}}, cnt_d};

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    token_d     = token_q;
    levels_d    = levels_q;
    if (fire && emit) begin
      out_valid_d = 1'b1;
      token_d     = tok;
      levels_d    = cnt_ext[LevelsW-1:0];
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.token  = token_q;
  assign out_o.levels = levels_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      flags_q     <= '0;
      saw_q       <= 1'b0;
      col_q       <= '0;
      wlen_q      <= '0;
      cnt_q       <= CntW'(1);
      top_q       <= '0;
      reload_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      flags_q     <= flags_d;
      saw_q       <= saw_d;
      col_q       <= col_d;
      wlen_q      <= wlen_d;
      cnt_q       <= cnt_d;
      top_q       <= top_d;
      reload_q    <= reload_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    wbuf_q   <= wbuf_d;
    token_q  <= token_d;
    levels_q <= levels_d;
  end

  // Status for checking.
  assign status_o.cnt_ok      = (cnt_q != '0) && (cnt_q <= CntW'(MaxLevels));
  assign status_o.reload_pend = reload_q;
  assign status_o.top_used    = fire && used_top;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking testbench for the offside-rule layout scanner
// Drives scan calls over the valid/ready input channel, keeps its own model
// of the indent stack, the column count and the statement-start test, and
// compares every result beat with the oldest predicted decision. Covers a
// short directed part, a wide tab column, random scans under several tab
// widths with idling on both sides and one long result hold, and a final
// run of nested levels.
// ============================================================================

module tb_top;
  import ols_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned FillLevels = 20;

  localparam logic [2:0] OnlyIndent = 3'(1 << FlIndent);
  localparam logic [2:0] OnlyDedent = 3'(1 << FlDedent);
  localparam logic [2:0] OnlySep    = 3'(1 << FlSep);

  // One predicted decision of a scan call.
  typedef struct packed {
    token_e     token;
    logic [9:0] levels;
  } layout_decision_t;

  // Scoreboard: tracks the scanner state and holds the decisions to come.
  class layout_scoreboard;
    logic [15:0]      stack_cols [MaxLevelsDef];
    int               depth;
    int               col;
    phase_e           phase;
    bit               saw_lf;
    logic [2:0]       allow;
    logic [55:0]      word_bits;
    int               word_len;
    logic [TabW-1:0]  tab_w;
    layout_decision_t pending [$];
    int               errors;

    function new();
      stack_cols[0] = '0;
      depth     = 1;
      col       = 0;
      phase     = PH_IDLE;
      saw_lf    = 1'b0;
      allow     = '0;
      word_bits = '0;
      word_len  = 0;
      tab_w     = TabWidthRst;
      errors    = 0;
    endfunction

    function automatic bit is_ident(logic [7:0] c);
      return c == CH_UNDER || (c >= CH_DIG_LO && c <= CH_DIG_HI) ||
             (c >= CH_LOW_LO && c <= CH_LOW_HI) || (c >= CH_UP_LO && c <= CH_UP_HI);
    endfunction

    function void add_col(int n);
      col = (col + n > 65535) ? 65535 : col + n;
    endfunction

    function void post_decision(token_e tok);
      layout_decision_t d;
      d.token  = tok;
      d.levels = depth[9:0];
      pending.push_back(d);
      phase = PH_DONE;
    endfunction

    // Compare the column with the stack top and pick the token.
    function void judge_layout(bit at_end, logic [7:0] c);
      int top;
      bit op_lead;
      if (!saw_lf) begin
        post_decision(TOK_NONE);
        return;
      end
      top = stack_cols[depth-1];
      if (allow[FlDedent] && col < top) begin
        if (depth > 1) depth--;
        post_decision(TOK_DEDENT);
        return;
      end
      if (allow == FlAll) begin
        post_decision(TOK_NONE);
        return;
      end
      if (allow[FlIndent] && col > top) begin
        if (depth < MaxLevelsDef) begin
          stack_cols[depth] = col[15:0];
          depth++;
        end
        post_decision(TOK_INDENT);
        return;
      end
      if (allow[FlSep] && !at_end && col == top) begin
        case (c)
          CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_LT, CH_GT, CH_EQ,
          CH_BANG, CH_CARET, CH_BAR, CH_DOT, CH_COMMA, CH_RPAREN, CH_RBRACK,
          CH_RBRACE: op_lead = 1'b1;
          default:   op_lead = 1'b0;
        endcase
        if (op_lead) begin
          post_decision(TOK_NONE);
        end else if (c == CH_UNDER) begin
          phase = PH_UNDER;
        end else if (c >= CH_LOW_LO && c <= CH_LOW_HI) begin
          word_bits = {48'b0, c};
          word_len  = 1;
          phase     = PH_WORD;
        end else begin
          post_decision(TOK_SEP);
        end
        return;
      end
      post_decision(TOK_NONE);
    endfunction

    // A finished lowercase word starts a statement unless it is a keyword.
    function void close_word();
      bit kw;
      kw = (word_len == 4 && (word_bits == {24'b0, KW_THEN} ||
                              word_bits == {24'b0, KW_ELSE} ||
                              word_bits == {24'b0, KW_ELIF} ||
                              word_bits == {24'b0, KW_WITH})) ||
           (word_len == 3 && word_bits == {24'b0, KW_AND}) ||
           (word_len == 2 && (word_bits == {24'b0, KW_OR} ||
                              word_bits == {24'b0, KW_IN}));
      post_decision(kw ? TOK_NONE : TOK_SEP);
    endfunction

    // Advance the model by one accepted input beat.
    function void note_input(logic [1:0] k, logic [7:0] c, logic [2:0] fl);
      if (k == KIND_START) begin
        allow     = fl;
        col       = 0;
        saw_lf    = 1'b0;
        word_bits = '0;
        word_len  = 0;
        phase     = PH_SPACE;
        return;
      end
      if (k == KIND_RSVD) return;
      case (phase)
        PH_SPACE: begin
          if (k == KIND_END) begin
            saw_lf = 1'b1;
            col    = 0;
            judge_layout(1'b1, 8'h00);
          end else if (c == CH_LF) begin
            saw_lf = 1'b1;
            col    = 0;
          end else if (c == CH_CR || c == CH_FF) begin
            col = 0;
          end else if (c == CH_SPACE) begin
            add_col(1);
          end else if (c == CH_TAB) begin
            add_col(int'(tab_w));
          end else if (c == CH_HASH) begin
            if (!saw_lf) post_decision(TOK_NONE);
            else phase = PH_COMMENT;
          end else begin
            judge_layout(1'b0, c);
          end
        end
        PH_COMMENT: begin
          if (k == KIND_END) begin
            saw_lf = 1'b1;
            col    = 0;
            judge_layout(1'b1, 8'h00);
          end else if (c == CH_LF) begin
            saw_lf = 1'b1;
            col    = 0;
            phase  = PH_SPACE;
          end
        end
        PH_UNDER: begin
          post_decision((k == KIND_CHAR && is_ident(c)) ? TOK_SEP : TOK_NONE);
        end
        PH_WORD: begin
          if (k == KIND_CHAR && is_ident(c)) begin
            if (word_len < 7) word_bits[8*word_len +: 8] = c;
            word_len++;
            if (word_len >= 8) post_decision(TOK_SEP);
          end else begin
            close_word();
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one result beat with the oldest predicted decision.
    function void check_result(logic [1:0] tok, logic [9:0] lvl);
      layout_decision_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with none predicted: token %0d levels %0d", $time, tok, lvl);
        return;
      end
      want = pending.pop_front();
      if (tok !== want.token) begin
        errors++;
        $display("%0t: token mismatch: expected %0d actual %0d", $time, want.token, tok);
      end
      if (lvl !== want.levels) begin
        errors++;
        $display("%0t: levels mismatch: expected %0d actual %0d", $time, want.levels, lvl);
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_ni;
  logic            cfg_we;
  logic [TabW-1:0] cfg_wdata;

  ols_in_if  in_ch ();
  ols_out_if out_ch ();

  layout_scoreboard sb;

  int unsigned items_sent = 0;
  int          gap_pct = 15;
  bit          stall_on = 1'b1;
  int          holds_asked = 0;
  int          holds_done = 0;

  logic [7:0] op_leads [16] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_LT,
                                CH_GT, CH_EQ, CH_BANG, CH_CARET, CH_BAR, CH_DOT,
                                CH_COMMA, CH_RPAREN, CH_RBRACK, CH_RBRACE};
  string keywords [7] = '{"then", "else", "elif", "with", "and", "or", "in"};

  offside_rule_layout_scanner dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_result(out_ch.token, out_ch.levels);
    end
  end

  // Result side: random stall bursts and, on request, one long hold.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk);
    forever begin
      if (holds_asked != holds_done) begin
        out_ch.ready <= 1'b0;
        for (n = 0; n < HoldCycles; n++) @(posedge clk);
        holds_done++;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Run limit.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Offer one input beat and wait for it to be taken.
  task automatic send_beat(input logic [1:0] k, input logic [7:0] c, input logic [2:0] fl);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= k;
    in_ch.ch           <= c;
    in_ch.allow_indent <= fl[FlIndent];
    in_ch.allow_dedent <= fl[FlDedent];
    in_ch.allow_sep    <= fl[FlSep];
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_input(k, c, fl);
    items_sent++;
  endtask

  task automatic send_start(input logic [2:0] fl);
    send_beat(KIND_START, 8'($urandom_range(0, 255)), fl);
  endtask

  task automatic send_char(input logic [7:0] c);
    send_beat(KIND_CHAR, c, 3'($urandom_range(0, 7)));
  endtask

  task automatic send_end();
    send_beat(KIND_END, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
  endtask

  task automatic send_word(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] ident_byte();
    case ($urandom_range(0, 3))
      0:       return 8'(CH_LOW_LO + $urandom_range(0, 25));
      1:       return 8'(CH_UP_LO + $urandom_range(0, 25));
      2:       return 8'(CH_DIG_LO + $urandom_range(0, 9));
      default: return CH_UNDER;
    endcase
  endfunction

  function automatic logic [7:0] non_lf_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_LF) ? CH_SPACE : b;
  endfunction

  // Spaces and tabs in mixed order that add up to column c.
  task automatic send_blanks(input int c, input bit dense);
    int tabs;
    int spaces;
    int tw;
    tw = int'(sb.tab_w);
    if (tw == 0) begin
      tabs   = $urandom_range(0, 2);
      spaces = c;
    end else begin
      tabs   = dense ? c / tw : $urandom_range(0, c / tw);
      spaces = c - tabs * tw;
    end
    while (tabs + spaces > 0) begin
      if (spaces == 0 || (tabs > 0 && $urandom_range(0, 1) == 1)) begin
        send_char(CH_TAB);
        tabs--;
      end else begin
        send_char(CH_SPACE);
        spaces--;
      end
    end
  endtask

  task automatic send_word_end();
    case ($urandom_range(0, 3))
      0:       send_char(CH_SPACE);
      1:       send_char("(");
      2:       send_end();
      default: send_char(8'($urandom_range(0, 255)));
    endcase
  endtask

  // Beats after the decision, mostly ignored by the block.
  task automatic send_tail();
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 3) == 0) send_end();
      else send_char(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic dedent_scan();
    send_start(OnlyDedent);
    send_char(CH_LF);
    send_end();
  endtask

  // Wait for all predicted results plus the pipeline latency.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_tab(input logic [TabW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.tab_w = v;
    cfg_we   <= 1'b0;
  endtask

  // One random scan call: mostly well formed, aimed around the stack top.
  task automatic random_scan();
    int shape;
    int sel;
    int c;
    int top;
    shape = $urandom_range(0, 9);
    send_start(3'($urandom_range(0, 7)));
    // No line end at all: the decision is no token, or the end item.
    if (shape == 0) begin
      send_blanks($urandom_range(0, 5), 1'b0);
      case ($urandom_range(0, 2))
        0:       send_char(CH_HASH);
        1:       send_end();
        default: send_char(ident_byte());
      endcase
      send_tail();
      return;
    end
    if ($urandom_range(0, 3) == 0) send_blanks($urandom_range(1, 6), 1'b0);
    send_char(CH_LF);
    if (shape == 1) begin
      // A comment line, possibly cut off by the end of input.
      send_blanks($urandom_range(0, 8), 1'b0);
      send_char(CH_HASH);
      repeat ($urandom_range(0, 5)) send_char(non_lf_byte());
      if ($urandom_range(0, 4) == 0) begin
        send_end();
        send_tail();
        return;
      end
      send_char(CH_LF);
    end else if (shape == 2) begin
      send_blanks($urandom_range(1, 9), 1'b0);
      send_char(($urandom_range(0, 1) == 1) ? CH_CR : CH_FF);
    end else if (shape == 3) begin
      send_blanks($urandom_range(0, 9), 1'b0);
      send_char(CH_LF);
    end
    // Pick the indentation relative to the current stack.
    top = sb.stack_cols[sb.depth-1];
    sel = (top > 100) ? 4 : $urandom_range(0, 5);
    case (sel)
      0, 1:    c = top;
      2:       c = top + $urandom_range(1, 12);
      3:       c = sb.stack_cols[$urandom_range(0, sb.depth - 1)];
      4:       c = (top > 0) ? $urandom_range(0, top - 1) : 0;
      default: c = $urandom_range(0, 40);
    endcase
    if (c > 300) c = $urandom_range(0, 40);
    send_blanks(c, 1'($urandom_range(0, 1)));
    // First token of the line.
    case ($urandom_range(0, 9))
      0: send_char(op_leads[$urandom_range(0, 15)]);
      1: begin
        send_char(CH_UNDER);
        send_char(ident_byte());
      end
      2: begin
        send_char(CH_UNDER);
        case ($urandom_range(0, 2))
          0:       send_char(CH_SPACE);
          1:       send_end();
          default: send_char(8'($urandom_range(0, 255)));
        endcase
      end
      3: begin
        send_word(keywords[$urandom_range(0, 6)]);
        send_word_end();
      end
      4, 5: begin
        send_char(8'(CH_LOW_LO + $urandom_range(0, 25)));
        repeat ($urandom_range(0, 9)) send_char(ident_byte());
        send_word_end();
      end
      6: send_end();
      7: begin
        send_char(CH_HASH);
        repeat ($urandom_range(0, 3)) send_char(non_lf_byte());
        send_char(CH_LF);
        send_blanks(c, 1'b1);
        send_char("a");
      end
      8: begin
        case ($urandom_range(0, 2))
          0:       send_char("(");
          1:       send_char(8'(CH_UP_LO + $urandom_range(0, 25)));
          default: send_char(8'(CH_DIG_LO + $urandom_range(0, 9)));
        endcase
      end
      default: send_char(8'($urandom_range(0, 255)));
    endcase
    send_tail();
  endtask

  // Random scans until the beat budget is spent; optionally one long hold.
  task automatic run_random(input int unsigned budget, input bit with_hold);
    int unsigned first;
    int scan_no;
    int calm;
    first   = items_sent;
    scan_no = 0;
    calm    = 0;
    while (items_sent - first < budget) begin
      if (with_hold && scan_no == 3) begin
        holds_asked++;
        calm = 40;
      end
      if (calm > 0) begin
        gap_pct = 0;
        calm--;
      end else begin
        gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 15;
      end
      // Noise: random beats of any kind, reserved kind included.
      if ($urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    3'($urandom_range(0, 7)));
        end
      end
      random_scan();
      scan_no++;
    end
  endtask

  // Main sequence.
  initial begin
    logic [TabW-1:0] widths [4];
    widths = '{5'd1, 5'd31, 5'd0, 5'd5};
    sb = new();
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = '0;
    in_ch.ch           = '0;
    in_ch.allow_indent = 1'b0;
    in_ch.allow_dedent = 1'b0;
    in_ch.allow_sep    = 1'b0;
    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Beats before any start are ignored.
    send_char("q");
    send_end();
    // Error recovery: deeper column, but only DEDENT may be emitted.
    send_start(FlAll);
    send_char(CH_LF);
    send_char(CH_SPACE);
    send_char("x");
    // Comment before any line end.
    send_start(OnlyIndent);
    send_char(CH_HASH);
    // Tab at the reset width pushes column 8.
    send_start(OnlyIndent);
    send_char(CH_LF);
    send_char(CH_TAB);
    send_char("a");
    // Skipped comment line, then an underscore that starts an identifier.
    send_start(OnlySep);
    send_char(CH_LF);
    send_char(CH_HASH);
    send_char("z");
    send_char(CH_LF);
    send_char(CH_TAB);
    send_char(CH_UNDER);
    send_char("k");
    // Continuation keyword at the same column.
    send_start(OnlySep);
    send_char(CH_LF);
    send_char(CH_TAB);
    send_char("o");
    send_char("r");
    send_char(";");
    // End of input counts as a line end at column zero.
    send_start(OnlyDedent);
    send_char(CH_LF);
    send_end();

    // A wide column at a tab width of 16.
    wait_idle();
    write_tab(5'd16);
    send_start(OnlyIndent);
    send_char(CH_LF);
    repeat (40) send_char(CH_TAB);
    send_char(CH_SPACE);
    send_char("a");
    dedent_scan();

    // Random scans under several tab widths, zero and the field maximum too.
    foreach (widths[i]) begin
      wait_idle();
      write_tab(widths[i]);
      run_random(260, i == 1);
    end

    // Last part without idling: a run of nested levels, then unwind a little.
    wait_idle();
    gap_pct  = 0;
    stall_on = 1'b0;
    write_tab(5'd16);
    while (sb.depth > 1) dedent_scan();
    for (int k = 1; k <= FillLevels; k++) begin
      send_start(OnlyIndent);
      send_char(CH_LF);
      send_blanks(k, 1'b1);
      send_char("a");
    end
    dedent_scan();
    dedent_scan();

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
